### hw/rtl/population_stddev_assert.svh
// Assertion macros for the population_stddev block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef POPULATION_STDDEV_ASSERT_SVH
`define POPULATION_STDDEV_ASSERT_SVH

// property checked on every clock edge outside reset
`define PSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define PSD_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### hw/rtl/psd_pkg.sv
// Shared constants, types and state codes for the population_stddev block.
// No dependencies.
`default_nettype none
package psd_pkg;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int COUNT_WIDTH   = 24;
    localparam int FRACTION_BITS = 16;

    localparam int RAW_WIDTH   = 16;
    localparam int DEV_WIDTH   = 32;
    localparam int TOTAL_WIDTH = 24;

    localparam int VAL_W  = SAMPLE_WIDTH + 1;
    localparam int SUM_W  = COUNT_WIDTH + SAMPLE_WIDTH + 1;
    localparam int SQ_W   = COUNT_WIDTH + 2 * SAMPLE_WIDTH;
    localparam int MP_W   = SUM_W;
    localparam int PROD_W = 2 * SUM_W;
    localparam int TGT_W  = COUNT_WIDTH + SQ_W;
    localparam int ROOT_W = (TGT_W + 2 * FRACTION_BITS + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int MAXSTEP = (ROOT_W > MP_W) ? ROOT_W : MP_W;
    localparam int STEP_W = $clog2(MAXSTEP);
    localparam int QX_W   = (ROOT_W > DEV_WIDTH) ? ROOT_W : DEV_WIDTH;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = 3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_FRACTION  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] value;   // two's complement sample after abs
        logic             has;
        logic             last;
    } queue_entry_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL1,
        ST_MUL2,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

### hw/rtl/psd_front.sv
// Input side: takes requests, reads the sample per config, forms queue entries.
// Depends on psd_pkg.
`default_nettype none
module psd_front
    import psd_pkg::*;
(
    input  wire logic [RAW_WIDTH-1:0] sample_bits,
    input  wire logic                 has_sample,
    input  wire logic                 last_item,
    input  wire logic                 in_valid,
    input  wire logic                 q_full,
    input  wire logic                 signed_samples,
    input  wire logic                 abs_mode,
    output logic                      q_push,
    output queue_entry_t              q_entry
);
    logic [SAMPLE_WIDTH-1:0] raw;
    logic signed [VAL_W-1:0] v;

    always_comb
    begin
        raw = SAMPLE_WIDTH'(sample_bits);
        v = $signed({signed_samples & raw[SAMPLE_WIDTH-1], raw});
        if (abs_mode && v[VAL_W-1])
        begin
            v = -v;
        end
        q_entry.value = v;
        q_entry.has   = has_sample;
        q_entry.last  = last_item;
        q_push = in_valid && !q_full;
    end
endmodule
`default_nettype wire

### hw/rtl/psd_queue.sv
// Short FIFO between the front and back parts.
// Depends on psd_pkg.
`default_nettype none
module psd_queue
    import psd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  queue_entry_t      push_entry,
    input  wire logic         pop,
    output logic              q_valid,
    output logic              q_full,
    output logic [QLVL_W-1:0] q_level,
    output queue_entry_t      head
);
    queue_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_reg, wr_next, rd_reg, rd_next;
    logic [QLVL_W-1:0]       lvl_reg, lvl_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        lvl_next = lvl_reg + QLVL_W'(push) - QLVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    assign head    = mem_reg[rd_reg];
    assign q_valid = lvl_reg != '0;
    assign q_full  = lvl_reg == QLVL_W'(QDEPTH);
    assign q_level = lvl_reg;
endmodule
`default_nettype wire

### hw/rtl/psd_back.sv
// Back part: run accumulators, serial multiply, square root and divide, result register.
// Depends on psd_pkg.
`default_nettype none
module psd_back
    import psd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  queue_entry_t                head,
    output logic                        pop,
    input  wire logic                   keep_fraction,
    input  wire logic                   out_stall,
    output logic                        out_valid,
    output logic [DEV_WIDTH-1:0]        deviation,
    output logic [TOTAL_WIDTH-1:0]      sample_total,
    output logic                        count_overflow
);
    state_t state_reg, state_next;

    logic [COUNT_WIDTH-1:0]  cnt_reg, acc_cnt;
    logic signed [SUM_W-1:0] sum_reg, acc_sum;
    logic [SQ_W-1:0]         sq_reg, acc_sq;
    logic                    ovf_reg, acc_ovf;

    logic [COUNT_WIDTH-1:0]  n_reg;
    logic                    ovf_snap_reg;
    logic [PROD_W-1:0]       mcand_reg, prod_reg, prod_step;
    logic [MP_W-1:0]         mplier_reg;
    logic [TGT_W-1:0]        tgt_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [ROOT_W+1:0]       rem_reg, rem_sh, trial, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [COUNT_WIDTH:0]    drem_reg, drem_sh, drem_next;
    logic [ROOT_W-1:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]       step_reg;
    logic                    mul_done, long_done, take_last, out_free;

    logic signed [VAL_W-1:0] hv;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [2*SAMPLE_WIDTH-1:0] mag_sq;
    logic [VAL_W-1:0]        neg_v;
    logic [SUM_W-1:0]        abs_sum;
    logic [QX_W-1:0]         quo_x;
    logic [DEV_WIDTH-1:0]    dev_val;

    // accumulate the head entry
    always_comb
    begin
        hv     = $signed(head.value);
        neg_v  = VAL_W'(-hv);
        mag    = hv[VAL_W-1] ? SAMPLE_WIDTH'(neg_v) : SAMPLE_WIDTH'(head.value);
        mag_sq = mag * mag;
        acc_cnt = cnt_reg;
        acc_sum = sum_reg;
        acc_sq  = sq_reg;
        acc_ovf = ovf_reg;
        if (pop && head.has)
        begin
            if (cnt_reg == '1)
            begin
                acc_ovf = 1'b1;
            end
            else
            begin
                acc_cnt = cnt_reg + 1'b1;
                acc_sum = sum_reg + {{(SUM_W-VAL_W){hv[VAL_W-1]}}, hv};
                acc_sq  = sq_reg + SQ_W'(mag_sq);
            end
        end
        abs_sum = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);
    end

    // serial datapath step values
    always_comb
    begin
        prod_step = prod_reg + (mplier_reg[0] ? mcand_reg : '0);
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rem_next  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        root_next = {root_reg[ROOT_W-2:0], rem_sh >= trial};
        drem_sh   = {drem_reg[COUNT_WIDTH-1:0], quo_reg[ROOT_W-1]};
        drem_next = (drem_sh >= {1'b0, n_reg}) ? drem_sh - {1'b0, n_reg} : drem_sh;
        quo_next  = {quo_reg[ROOT_W-2:0], drem_sh >= {1'b0, n_reg}};
        quo_x     = QX_W'(quo_reg);
        dev_val   = (|(quo_x >> DEV_WIDTH)) ? '1 : DEV_WIDTH'(quo_x);
        if (!keep_fraction)
        begin
            dev_val = dev_val & ~((DEV_WIDTH'(1) << FRACTION_BITS) - 1'b1);
        end
    end

    // FSM outputs
    always_comb
    begin
        mul_done  = step_reg == STEP_W'(MP_W - 1);
        long_done = step_reg == STEP_W'(ROOT_W - 1);
        out_free  = !out_valid || !out_stall;
        // a closing entry waits until the result unit is free
        pop       = q_valid && (!head.last || state_reg == ST_ACC);
        take_last = pop && head.last;
    end

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (take_last)
                begin
                    state_next = (acc_cnt == '0) ? ST_OUT : ST_MUL1;
                end
            end
            ST_MUL1: if (mul_done) state_next = ST_MUL2;
            ST_MUL2: if (mul_done) state_next = ST_ROOT;
            ST_ROOT: if (long_done) state_next = ST_DIV;
            ST_DIV:  if (long_done) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_ACC;
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            ovf_reg   <= 1'b0;
            out_valid <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_last)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= acc_cnt;
                sum_reg <= acc_sum;
                sq_reg  <= acc_sq;
                ovf_reg <= acc_ovf;
            end
            if (state_next != state_reg)
            begin
                step_reg <= '0;
            end
            else if (state_reg != ST_ACC && state_reg != ST_OUT)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_ACC:
            begin
                if (take_last)
                begin
                    n_reg        <= acc_cnt;
                    ovf_snap_reg <= acc_ovf;
                    mcand_reg    <= PROD_W'(acc_sq);
                    mplier_reg   <= MP_W'(acc_cnt);
                    prod_reg     <= '0;
                    tgt_reg      <= '0;
                    quo_reg      <= '0;
                    drem_reg     <= '0;
                    rem_reg      <= '0;
                    root_reg     <= '0;
                    rad_reg      <= '0;
                end
                if (take_last)
                begin
                    mcand_reg <= PROD_W'(acc_sq);
                end
                // magnitude of the sum is kept in tgt for the second pass
                if (take_last)
                begin
                    tgt_reg <= TGT_W'(abs_sum);
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    mcand_reg  <= PROD_W'(tgt_reg);
                    mplier_reg <= MP_W'(tgt_reg);
                    prod_reg   <= '0;
                    tgt_reg    <= TGT_W'(prod_step);
                end
                else
                begin
                    prod_reg   <= prod_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    rad_reg  <= RAD_W'(tgt_reg - TGT_W'(prod_step)) << (2 * FRACTION_BITS);
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    prod_reg   <= prod_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ST_ROOT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                if (long_done)
                begin
                    quo_reg  <= root_next;
                    drem_reg <= '0;
                end
            end
            ST_DIV:
            begin
                drem_reg <= drem_next;
                quo_reg  <= quo_next;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    deviation      <= dev_val;
                    sample_total   <= TOTAL_WIDTH'(n_reg);
                    count_overflow <= ovf_snap_reg;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/population_stddev.sv
// Top level of the population standard deviation block: config registers and wiring.
// Depends on psd_pkg, psd_front, psd_queue, psd_back, population_stddev_assert.svh.
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall | sample_bits, has_sample, last_item
//  out     | out_valid/out_stall | deviation, sample_total, count_overflow
//  cfg     | cfg_write           | cfg_index, cfg_data
//
// Samples are taken one per cycle into a 4-entry queue while it is not full, and summed
// at one per cycle unless a closing item waits. A closing item starts the result unit:
// two serial multiplies of 41 steps, a square root of 56 steps and a divide of 56 steps.
// Samples of the next run keep accumulating meanwhile; its closing item waits.
// Reset clears the run, the queue and the output valid flag; a stalled output holds.
`default_nettype none
`include "population_stddev_assert.svh"
module population_stddev
    import psd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [RAW_WIDTH-1:0]   sample_bits,
    input  wire logic                   has_sample,
    input  wire logic                   last_item,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [DEV_WIDTH-1:0]        deviation,
    output logic [TOTAL_WIDTH-1:0]      sample_total,
    output logic                        count_overflow,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic                   cfg_data
);
    logic signed_reg, abs_reg, keep_reg;
    logic q_push, q_full, q_valid, q_pop;
    logic [QLVL_W-1:0] q_level;
    queue_entry_t push_entry, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_reg <= 1'b1;
            abs_reg    <= 1'b0;
            keep_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SIGNED_SAMPLES: signed_reg <= cfg_data;
                REG_ABS_MODE:       abs_reg    <= cfg_data;
                REG_KEEP_FRACTION:  keep_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = q_full;

    psd_front u_front (
        .sample_bits    (sample_bits),
        .has_sample     (has_sample),
        .last_item      (last_item),
        .in_valid       (in_valid),
        .q_full         (q_full),
        .signed_samples (signed_reg),
        .abs_mode       (abs_reg),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    psd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .q_level    (q_level),
        .head       (head)
    );

    psd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .head           (head),
        .pop            (q_pop),
        .keep_fraction  (keep_reg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .deviation      (deviation),
        .sample_total   (sample_total),
        .count_overflow (count_overflow)
    );

    `PSD_ASSERT(a_level_bound, q_level <= QLVL_W'(QDEPTH), "queue level above depth")
    `PSD_ASSERT_IMP(a_level_up, q_push && !q_pop, ##1 q_level == $past(q_level) + 1'b1, "queue level lost a request")
    `PSD_ASSERT_IMP(a_ovf_total, out_valid && count_overflow, sample_total == '1, "overflow without full count")
endmodule
`default_nettype wire

### verif/population_stddev_tb.sv
// Testbench for population_stddev: drives sample runs with random gaps and stalls,
// predicts each run's deviation, count and overflow flag, and checks every result.
// Depends on psd_pkg and the population_stddev RTL.
`timescale 1ns / 1ps
module population_stddev_tb;
    import psd_pkg::*;

    typedef struct {
        logic [RAW_WIDTH-1:0] bits;
        logic                 has;
        logic                 last;
    } sample_req_t;

    typedef struct {
        logic [DEV_WIDTH-1:0]   dev;
        logic [TOTAL_WIDTH-1:0] total;
        logic                   ovf;
    } dev_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [RAW_WIDTH-1:0] sample_bits = '0;
    logic has_sample = 1'b0;
    logic last_item = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DEV_WIDTH-1:0] deviation;
    logic [TOTAL_WIDTH-1:0] sample_total;
    logic count_overflow;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic cfg_data = 1'b0;

    population_stddev u_top (.*);

    always #5 clk = ~clk;

    // predictor state and config copy
    logic pred_signed = 1'b1;
    logic pred_abs = 1'b0;
    logic pred_frac = 1'b1;
    logic [23:0] acc_count = '0;
    logic signed [63:0] acc_sum = '0;
    logic [63:0] acc_sq = '0;
    logic acc_ovf = 1'b0;

    sample_req_t pending_reqs[$];
    dev_result_t expected_devs[$];
    int errors = 0;
    int results_seen = 0;
    int runs_sent = 0;
    int long_hold = 0;
    bit gen_done = 0;
    bit pause_sender = 0;
    bit in_taken = 0;
    longint cycles = 0;

    function automatic logic [31:0] isqrt_dev(logic [23:0] n, logic signed [63:0] s,
                                               logic [63:0] q, logic frac);
        logic [127:0] target;
        logic [63:0] mag;
        logic [31:0] r;
        logic [31:0] cand;
        logic [127:0] p;
        if (n == 0)
            return '0;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        target = (128'(n) * 128'(q) - 128'(mag) * 128'(mag)) << (2 * FRACTION_BITS);
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = r | (32'd1 << b);
            p = 128'(cand) * 128'(n);
            if (p * p <= target)
                r = cand;
        end
        if (!frac)
            r &= ~32'((64'd1 << FRACTION_BITS) - 1);
        return r;
    endfunction

    task automatic predict_sample(sample_req_t r);
        logic signed [63:0] v;
        dev_result_t e;
        if (r.has)
        begin
            if (acc_count == 24'hFFFFFF)
                acc_ovf = 1'b1;
            else
            begin
                v = {48'd0, r.bits};
                if (pred_signed && r.bits[SAMPLE_WIDTH-1])
                    v -= 64'sd1 << SAMPLE_WIDTH;
                if (pred_abs && v < 0)
                    v = -v;
                acc_count++;
                acc_sum += v;
                acc_sq += 64'(v * v);
            end
        end
        if (r.last)
        begin
            e.dev = isqrt_dev(acc_count, acc_sum, acc_sq, pred_frac);
            e.total = acc_count;
            e.ovf = acc_ovf;
            expected_devs.push_back(e);
            acc_count = '0;
            acc_sum = '0;
            acc_sq = '0;
            acc_ovf = 1'b0;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SIGNED_SAMPLES: pred_signed = val;
            REG_ABS_MODE:       pred_abs = val;
            REG_KEEP_FRACTION:  pred_frac = val;
            default:            ;
        endcase
    endtask

    task automatic push_req(logic [15:0] b, logic h, logic l);
        sample_req_t r;
        r.bits = b;
        r.has = h;
        r.last = l;
        pending_reqs.push_back(r);
        if (l)
            runs_sent++;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_devs.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_run(int len);
        int kind;
        logic [15:0] b;
        for (int i = 0; i < len; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
                b = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else if (kind < 4)
                b = 16'($urandom_range(0, 15) - 8);
            else
                b = 16'($urandom);
            push_req(b, $urandom_range(0, 15) != 0, 1'b0);
        end
        push_req(16'($urandom), $urandom_range(0, 3) != 0, 1'b1);
    endtask

    // request handshake seen at the rising edge
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
    end

    // driver: bursts and gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0 || pause_sender || pending_reqs.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                sample_bits <= pending_reqs[0].bits;
                has_sample <= pending_reqs[0].has;
                last_item <= pending_reqs[0].last;
                in_valid <= 1'b1;
                predict_sample(pending_reqs.pop_front());
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    int stall_phase = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (long_hold > 0)
        begin
            out_stall <= 1'b1;
            long_hold <= long_hold - 1;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 40;
            out_stall <= (stall_phase < 20) ? ($urandom_range(0, 3) == 0) : 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        dev_result_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_devs.size() == 0)
            begin
                $error("unexpected result dev=%h total=%0d", deviation, sample_total);
                errors++;
            end
            else
            begin
                e = expected_devs.pop_front();
                if (deviation !== e.dev)
                begin
                    $error("deviation exp %h got %h", e.dev, deviation);
                    errors++;
                end
                if (sample_total !== e.total)
                begin
                    $error("sample_total exp %0d got %0d", e.total, sample_total);
                    errors++;
                end
                if (count_overflow !== e.ovf)
                begin
                    $error("count_overflow exp %0d got %0d", e.ovf, count_overflow);
                    errors++;
                end
            end
        end
        if (cycles > 2000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int sent;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, empty run, unsigned/abs, whole-number mode
        push_req(16'h0000, 1'b0, 1'b1);
        push_req(16'h7FFF, 1'b1, 1'b0);
        push_req(16'h8000, 1'b1, 1'b1);
        push_req(16'h1234, 1'b0, 1'b0);
        push_req(16'hFFFF, 1'b1, 1'b0);
        push_req(16'h0001, 1'b1, 1'b0);
        push_req(16'h0005, 1'b1, 1'b1);
        push_req(16'h0042, 1'b1, 1'b1);
        drain();
        write_reg(REG_SIGNED_SAMPLES, 1'b0);
        write_reg(REG_KEEP_FRACTION, 1'b0);
        push_req(16'hFFFF, 1'b1, 1'b0);
        push_req(16'h0000, 1'b1, 1'b0);
        push_req(16'h0003, 1'b1, 1'b1);
        push_req(16'h8001, 1'b1, 1'b1);
        drain();
        write_reg(REG_SIGNED_SAMPLES, 1'b1);
        write_reg(REG_ABS_MODE, 1'b1);
        push_req(16'hFFFE, 1'b1, 1'b0);
        push_req(16'h0002, 1'b1, 1'b0);
        push_req(16'h8000, 1'b1, 1'b1);
        drain();

        // random phases under varying settings
        sent = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_SIGNED_SAMPLES, 1'($urandom_range(0, 1)));
            write_reg(REG_ABS_MODE, 1'($urandom_range(0, 1)));
            write_reg(REG_KEEP_FRACTION, 1'(ph % 2));
            while (sent < (ph + 1) * 112)
            begin
                int len;
                len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 25);
                random_run(len);
                sent += len + 1;
            end
            if (ph == 2)
                long_hold = 1500;
            if (ph == 5)
            begin
                // let part of the phase go out, then wait for all results
                repeat (200) @(posedge clk);
                pause_sender = 1;
                while (expected_devs.size() != 0)
                    @(posedge clk);
                pause_sender = 0;
            end
            drain();
        end

        $display("Covered %0d runs, %0d results checked, all register settings used.",
                 runs_sent, results_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
